/* sv/tgarle_pkg.sv */
`timescale 1ns / 1ps

package tgarle_pkg;

    // Packet header layout.
    localparam int unsigned HDR_REPEAT_BIT = 7;
    localparam logic [6:0]  HDR_COUNT_MASK = 7'h7f;

    // Field widths.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PIXEL_W = 32;
    localparam int unsigned RUN_W   = 8;
    localparam int unsigned PBYTES_W = 3;

    // Register map: index is the word address.
    localparam logic REG_PIXEL_BYTES  = 1'b0;
    localparam logic REG_IMAGE_PIXELS = 1'b1;

    localparam logic [PBYTES_W-1:0] PIXEL_BYTES_RESET  = 3'd4;
    localparam logic [31:0]         IMAGE_PIXELS_RESET = 32'd1;

    // Depth of the job queue between the front and back ends.
    localparam int unsigned QUEUE_DEPTH = 2;

    // One decoded pixel and the number of times it is to be emitted.
    typedef struct packed {
        logic [PIXEL_W-1:0] pix;
        logic [RUN_W-1:0]   cnt;
        logic               done;
    } t_job;

    // Job hand-off from the front end to the queue.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_push;

endpackage

/* sv/tga_rle_pixel_decoder_unit.sv */
`timescale 1ns / 1ps

// TGA run-length pixel decoder. Compressed image bytes enter one word per
// cycle through a push/full queue port; decoded pixels leave through an
// empty/pop queue port, up to two per word. A front end parses packet headers
// and assembles pixels byte by byte and places each completed pixel, with its
// repeat count, into a two-entry job queue; full follows that queue. The back
// end emits one result word per cycle while its output is free, so a repeat
// packet of n pixels fills ceil(n/2) words and a literal pixel one. Pixels past
// the configured image size are dropped. Registers: pixel_bytes at address 0
// and image_pixels at address 4; write them only while the decoder is idle.
module tga_rle_pixel_decoder_unit
    import tgarle_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [BYTE_W-1:0]   i_in_byte,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [PIXEL_W-1:0]  o_pixel_first,
    output logic [PIXEL_W-1:0]  o_pixel_second,
    output logic [1:0]          o_pixel_count,
    output logic                o_run_last,
    output logic                o_image_done,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [PBYTES_W-1:0] r_pixel_bytes;
    logic [31:0]         r_image_pixels;
    logic                cfg_wr;
    logic                accept;
    t_job_push           push;
    t_job                head;
    logic                head_empty;
    logic                head_pop;

    // Configuration registers; byte offset bits are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes  <= PIXEL_BYTES_RESET;
            r_image_pixels <= IMAGE_PIXELS_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PIXEL_BYTES:  r_pixel_bytes  <= pwdata[PBYTES_W-1:0];
                REG_IMAGE_PIXELS: r_image_pixels <= pwdata;
                default:          r_image_pixels <= r_image_pixels;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PIXEL_BYTES:  prdata = {{(32-PBYTES_W){1'b0}}, r_pixel_bytes};
            REG_IMAGE_PIXELS: prdata = r_image_pixels;
            default:          prdata = '0;
        endcase
    end

    assign accept = i_push && !o_full;

    tgarle_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in_byte      (i_in_byte),
        .i_pixel_bytes  (r_pixel_bytes),
        .i_image_pixels (r_image_pixels),
        .o_push         (push)
    );

    tgarle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (head_pop),
        .o_head  (head),
        .o_full  (o_full),
        .o_empty (head_empty)
    );

    tgarle_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_head_empty   (head_empty),
        .o_head_pop     (head_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_pixel_first  (o_pixel_first),
        .o_pixel_second (o_pixel_second),
        .o_pixel_count  (o_pixel_count),
        .o_run_last     (o_run_last),
        .o_image_done   (o_image_done)
    );

endmodule

/* sv/tgarle_front.sv */
`timescale 1ns / 1ps

module tgarle_front
    import tgarle_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [BYTE_W-1:0]   i_in_byte,
    input  logic [PBYTES_W-1:0] i_pixel_bytes,
    input  logic [31:0]         i_image_pixels,
    output t_job_push           o_push
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_REPEAT,
        PH_LITERAL
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [RUN_W-1:0]   r_left, n_left;
    logic [PIXEL_W-1:0] r_asm, n_asm;
    logic [1:0]         r_bip, n_bip;
    logic [31:0]        r_emitted, n_emitted;

    logic [PBYTES_W-1:0] eff_bytes;
    logic [2:0]          bip_inc;
    logic [PIXEL_W-1:0]  asm_next;
    logic [31:0]         remain;
    logic                img_end;
    logic                hdr;
    logic                clip;
    logic [RUN_W-1:0]    left_dec;

    // Effective pixel size: zero acts as one byte, anything above four as four.
    always_comb begin
        if (i_pixel_bytes == '0) begin
            eff_bytes = 3'd1;
        end else if (i_pixel_bytes > 3'd4) begin
            eff_bytes = 3'd4;
        end else begin
            eff_bytes = i_pixel_bytes;
        end
    end

    assign img_end  = (r_emitted >= i_image_pixels);
    assign remain   = i_image_pixels - r_emitted;
    assign hdr      = (r_phase == PH_HEADER) || (r_left == '0);
    assign bip_inc  = {1'b0, r_bip} + 3'd1;
    assign asm_next = r_asm | ({{(PIXEL_W-BYTE_W){1'b0}}, i_in_byte} << {r_bip, 3'b000});
    assign clip     = ({{(32-RUN_W){1'b0}}, r_left} >= remain);
    assign left_dec = r_left - RUN_W'(1);

    // Classify each accepted word and work out the job it produces.
    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_asm     = r_asm;
        n_bip     = r_bip;
        n_emitted = r_emitted;
        o_push    = '0;
        if (i_accept && !img_end) begin
            if (hdr) begin
                n_left  = {1'b0, i_in_byte[6:0] & HDR_COUNT_MASK} + RUN_W'(1);
                n_phase = i_in_byte[HDR_REPEAT_BIT] ? PH_REPEAT : PH_LITERAL;
                n_asm   = '0;
                n_bip   = '0;
            end else if (bip_inc < eff_bytes) begin
                n_asm = asm_next;
                n_bip = bip_inc[1:0];
            end else begin
                n_asm          = '0;
                n_bip          = '0;
                o_push.valid   = 1'b1;
                o_push.job.pix = asm_next;
                if (r_phase == PH_REPEAT) begin
                    // A run is clipped to the pixels the image still needs.
                    o_push.job.cnt  = clip ? remain[RUN_W-1:0] : r_left;
                    o_push.job.done = clip;
                    n_emitted       = clip ? i_image_pixels
                                           : r_emitted + {{(32-RUN_W){1'b0}}, r_left};
                    n_left          = '0;
                    n_phase         = PH_HEADER;
                end else begin
                    o_push.job.cnt  = RUN_W'(1);
                    o_push.job.done = (remain == 32'd1);
                    n_emitted       = r_emitted + 32'd1;
                    n_left          = left_dec;
                    if (left_dec == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
            end
        end
    end

    // Decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_left    <= '0;
            r_asm     <= '0;
            r_bip     <= '0;
            r_emitted <= '0;
        end else begin
            r_phase   <= n_phase;
            r_left    <= n_left;
            r_asm     <= n_asm;
            r_bip     <= n_bip;
            r_emitted <= n_emitted;
        end
    end

endmodule

/* sv/tgarle_queue.sv */
`timescale 1ns / 1ps

module tgarle_queue
    import tgarle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_push i_push,
    input  logic      i_pop,
    output t_job      o_head,
    output logic      o_full,
    output logic      o_empty
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* sv/tgarle_back.sv */
`timescale 1ns / 1ps

module tgarle_back
    import tgarle_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_job               i_head,
    input  logic               i_head_empty,
    output logic               o_head_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [PIXEL_W-1:0] o_pixel_first,
    output logic [PIXEL_W-1:0] o_pixel_second,
    output logic [1:0]         o_pixel_count,
    output logic               o_run_last,
    output logic               o_image_done
);

    logic               r_act;
    logic [PIXEL_W-1:0] r_pix;
    logic [RUN_W-1:0]   r_left;
    logic               r_done;
    logic               r_out_valid;

    logic               out_free;
    logic               src_valid;
    logic [PIXEL_W-1:0] cur_pix;
    logic [RUN_W-1:0]   cur_left;
    logic               cur_done;
    logic               pair;
    logic [RUN_W-1:0]   left_n;
    logic               emit;

    // The job in progress comes first, otherwise the queue head.
    assign out_free  = !r_out_valid || i_pop;
    assign src_valid = r_act || !i_head_empty;
    assign cur_pix   = r_act ? r_pix  : i_head.pix;
    assign cur_left  = r_act ? r_left : i_head.cnt;
    assign cur_done  = r_act ? r_done : i_head.done;
    assign pair      = (cur_left >= RUN_W'(2));
    assign left_n    = cur_left - (pair ? RUN_W'(2) : RUN_W'(1));
    assign emit      = src_valid && out_free;
    assign o_head_pop = emit && !r_act;
    assign o_empty    = !r_out_valid;

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_pixel_first  <= cur_pix;
            o_pixel_second <= pair ? cur_pix : '0;
            o_pixel_count  <= pair ? 2'd2 : 2'd1;
            o_run_last     <= (left_n == '0);
            o_image_done   <= (left_n == '0) && cur_done;
        end
    end

    // Run progress and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                r_act       <= (left_n != '0);
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A run that needs more words keeps its pixel here.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pix  <= cur_pix;
            r_left <= left_n;
            r_done <= cur_done;
        end
    end

endmodule
